>>> src/expiring_loglog_three_stage_filter_unit_assert.svh
// Assertion macros used by the filter RTL.
// Depends on signals named clk and arst_n in the including module.
`ifndef EXPIRING_LOGLOG_THREE_STAGE_FILTER_UNIT_ASSERT_SVH
`define EXPIRING_LOGLOG_THREE_STAGE_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define ELLF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ELLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ellf_pkg.sv
// Shared types, constants, the rank function and the entry update function of the filter.
// No dependencies.
`default_nettype none
package ellf_pkg;
	localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2  = 32'h1b873593;
	localparam logic [31:0] MUR_C3  = 32'h85ebca6b;
	localparam logic [31:0] MUR_C4  = 32'hc2b2ae35;
	localparam logic [31:0] MUR_ADD = 32'he6546b64;
	localparam logic [31:0] MUR_LEN = 32'd4;
	localparam logic [5:0]  RANK_LIMIT = 6'd33;

	typedef enum logic [1:0] {
		REG_SEED_ONE, REG_SEED_TWO, REG_SEED_THREE, REG_THRESHOLD
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] key;
		logic        start;
		logic [5:0]  rank1;
		logic [5:0]  rank2;
		logic [5:0]  rank3;
	} item_info_t;

	typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_HOLD} front_state_t;
	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_UPDATE} back_state_t;

	function automatic logic [5:0] rank_of(input logic [31:0] w);
		logic [5:0] pos;
		pos = '0;
		for (int i = 1; i < 31; i++) begin
			if (w[i]) pos = 6'(i);
		end
		if (w[31] || (w[30:1] == 30'd0)) return RANK_LIMIT;
		return RANK_LIMIT - pos;
	endfunction

	// entry: flag in bit 6, counter in bits 5:0
	function automatic logic [6:0] entry_update(input logic [6:0] e, input logic [5:0] rank,
	                                           input logic start);
		logic [5:0] cnt;
		cnt = e[5:0];
		if (start) begin
			if (e[6]) cnt = rank;
			else if (cnt < rank) cnt = rank;
			return {1'b0, cnt};
		end
		return {1'b1, cnt};
	endfunction
endpackage
`default_nettype wire

>>> src/ellf_front.sv
// Front part: accepts items, hashes the key per stage, reduces hash and arrival index.
// Depends on ellf_pkg.
`default_nettype none
module ellf_front #(
	parameter int              BUCKETS       = 4096,
	parameter longint unsigned WINDOW_LENGTH = 1000000,
	parameter int              IDX_W         = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       enable,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [159:0]               in_data,
	input  wire logic [2:0][31:0]           seeds,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output ellf_pkg::item_info_t            push_info,
	output logic [2:0][IDX_W-1:0]           push_idx
);
	// floor(2^32 / divisor): the quotient estimate is low by at most one
	localparam logic [31:0] RECIP_W = 32'((64'd1 << 32) / WINDOW_LENGTH);
	localparam logic [31:0] RECIP_B = 32'((64'd1 << 32) / 64'(BUCKETS));

	ellf_pkg::front_state_t state_q, state_d;
	logic [4:0]              step_q;
	logic [31:0]             key_q, arr_q, arem_q, m_q;
	logic [5:0]              rank_q [3];
	logic [2:0][31:0]        h_q;
	logic [2:0][IDX_W-1:0]   hrem_q;
	logic [31:0]             qa_q;
	logic [2:0][31:0]        qh_q;
	logic [32:0]             ra_q;
	logic [2:0][IDX_W:0]     rh_q;
	logic [63:0]             pa;
	logic [2:0][63:0]        ph;
	logic [32:0]             aext;
	logic [2:0][IDX_W:0]     hext;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ellf_pkg::F_IDLE: if (in_valid && in_ready) state_d = ellf_pkg::F_HASH;
			ellf_pkg::F_HASH: if (step_q == 5'd5) state_d = ellf_pkg::F_MOD;
			ellf_pkg::F_MOD:  if (step_q == 5'd2) state_d = ellf_pkg::F_HOLD;
			ellf_pkg::F_HOLD: if (push_ready) state_d = ellf_pkg::F_IDLE;
			default:          state_d = ellf_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ellf_pkg::F_IDLE) && enable;
		push_valid      = (state_q == ellf_pkg::F_HOLD);
		push_info.key   = key_q;
		push_info.start = (arem_q == 32'd1);
		push_info.rank1 = rank_q[0];
		push_info.rank2 = rank_q[1];
		push_info.rank3 = rank_q[2];
		push_idx        = hrem_q;
	end

	// reciprocal estimate, then one compare and subtract
	always_comb begin
		pa   = 64'(arr_q) * 64'(RECIP_W);
		aext = (ra_q >= 33'(WINDOW_LENGTH)) ? ra_q - 33'(WINDOW_LENGTH) : ra_q;
		for (int i = 0; i < 3; i++) begin
			ph[i]   = 64'(h_q[i]) * 64'(RECIP_B);
			hext[i] = (rh_q[i] >= (IDX_W+1)'(BUCKETS)) ? rh_q[i] - (IDX_W+1)'(BUCKETS)
			                                           : rh_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ellf_pkg::F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) step_q <= '0;
			else if (state_q == ellf_pkg::F_HASH || state_q == ellf_pkg::F_MOD)
				step_q <= step_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ellf_pkg::F_IDLE: begin
				key_q     <= in_data[31:0];
				arr_q     <= in_data[63:32];
				rank_q[0] <= ellf_pkg::rank_of(in_data[95:64]);
				rank_q[1] <= ellf_pkg::rank_of(in_data[127:96]);
				rank_q[2] <= ellf_pkg::rank_of(in_data[159:128]);
			end
			ellf_pkg::F_HASH: begin
				case (step_q)
					5'd0: m_q <= key_q * ellf_pkg::MUR_C1;
					5'd1: m_q <= {m_q[16:0], m_q[31:17]} * ellf_pkg::MUR_C2;
					5'd2: begin
						for (int i = 0; i < 3; i++) begin
							logic [31:0] h;
							h = seeds[i] ^ m_q;
							h = {h[18:0], h[31:19]};
							h = (h << 2) + h + ellf_pkg::MUR_ADD;
							h = h ^ ellf_pkg::MUR_LEN;
							h_q[i] <= h ^ (h >> 16);
						end
					end
					5'd3: for (int i = 0; i < 3; i++) h_q[i] <= h_q[i] * ellf_pkg::MUR_C3;
					5'd4: for (int i = 0; i < 3; i++)
						h_q[i] <= (h_q[i] ^ (h_q[i] >> 13)) * ellf_pkg::MUR_C4;
					default: begin
						for (int i = 0; i < 3; i++) h_q[i] <= h_q[i] ^ (h_q[i] >> 16);
					end
				endcase
			end
			ellf_pkg::F_MOD: begin
				case (step_q)
					5'd0: begin
						qa_q <= pa[63:32];
						for (int i = 0; i < 3; i++) qh_q[i] <= ph[i][63:32];
					end
					5'd1: begin
						ra_q <= {1'b0, arr_q} - 33'(qa_q) * 33'(WINDOW_LENGTH);
						for (int i = 0; i < 3; i++)
							rh_q[i] <= (IDX_W+1)'(h_q[i])
							           - (IDX_W+1)'(qh_q[i]) * (IDX_W+1)'(BUCKETS);
					end
					default: begin
						arem_q <= aext[31:0];
						for (int i = 0; i < 3; i++) hrem_q[i] <= hext[i][IDX_W-1:0];
					end
				endcase
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> src/ellf_queue.sv
// Two-entry queue between the front and back parts.
// No dependencies.
`default_nettype none
module ellf_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	logic [W-1:0] slot_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end
endmodule
`default_nettype wire

>>> src/ellf_back.sv
// Back part: clears the bucket tables, then does one read-modify-write per item.
// Depends on ellf_pkg and the assertion macro header.
`default_nettype none
`include "expiring_loglog_three_stage_filter_unit_assert.svh"
module ellf_back #(
	parameter int BUCKETS = 4096,
	parameter int IDX_W   = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	output logic                       clear_done,
	input  wire logic                  pop_valid,
	output logic                       pop_ready,
	input  wire ellf_pkg::item_info_t  pop_info,
	input  wire logic [2:0][IDX_W-1:0] pop_idx,
	input  wire logic [6:0]            threshold,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [31:0]                out_key,
	output logic                       out_over,
	output logic [6:0]                 out_sum
);
	ellf_pkg::back_state_t state_q, state_d;
	logic [IDX_W-1:0]      clr_q;
	ellf_pkg::item_info_t  info_s1;
	logic [2:0][IDX_W-1:0] idx_s1;
	logic [2:0][6:0]       rd_q, new_e;
	logic [5:0]            rank [3];
	logic [6:0]            sum;
	logic                  ovalid_q, over_q;
	logic [31:0]           key_q;
	logic [6:0]            sum_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ellf_pkg::B_CLEAR:  if (clr_q == IDX_W'(BUCKETS - 1)) state_d = ellf_pkg::B_IDLE;
			ellf_pkg::B_IDLE:   if (pop_valid && pop_ready) state_d = ellf_pkg::B_READ;
			ellf_pkg::B_READ:   state_d = ellf_pkg::B_UPDATE;
			ellf_pkg::B_UPDATE: state_d = ellf_pkg::B_IDLE;
			default:            state_d = ellf_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		clear_done = (state_q != ellf_pkg::B_CLEAR);
		pop_ready  = (state_q == ellf_pkg::B_IDLE) && !ovalid_q;
		out_valid  = ovalid_q;
		out_key    = key_q;
		out_over   = over_q;
		out_sum    = sum_q;
	end

	always_comb begin
		rank[0] = info_s1.rank1;
		rank[1] = info_s1.rank2;
		rank[2] = info_s1.rank3;
		for (int i = 0; i < 3; i++) new_e[i] = ellf_pkg::entry_update(rd_q[i], rank[i], info_s1.start);
		sum = {1'b0, new_e[0][5:0]} + {1'b0, new_e[1][5:0]} + {1'b0, new_e[2][5:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ellf_pkg::B_CLEAR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ellf_pkg::B_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (state_q == ellf_pkg::B_UPDATE) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ellf_pkg::B_IDLE) begin
			info_s1 <= pop_info;
			idx_s1  <= pop_idx;
		end
		if (state_q == ellf_pkg::B_UPDATE) begin
			over_q <= (sum > threshold);
			key_q  <= (sum > threshold) ? info_s1.key : 32'd0;
			sum_q  <= sum;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_table
		logic [6:0] mem [BUCKETS];
		always_ff @(posedge clk) begin
			if (state_q == ellf_pkg::B_CLEAR) mem[clr_q] <= 7'd0;
			else if (state_q == ellf_pkg::B_UPDATE) mem[idx_s1[g]] <= new_e[g];
			rd_q[g] <= mem[idx_s1[g]];
		end
	end

	`ELLF_ASSERT_NEXT(a_update_out, state_q == ellf_pkg::B_UPDATE, ovalid_q, "result not registered")
	`ELLF_ASSERT_NOW(a_no_pop_clear, state_q == ellf_pkg::B_CLEAR, !pop_ready, "pop during clear")
	`ELLF_ASSERT_NOW(a_flag_sum, ovalid_q, over_q == (sum_q > threshold), "flag disagrees with sum")
endmodule
`default_nettype wire

>>> src/expiring_loglog_three_stage_filter_unit.sv
// Top level of the three-stage expiring LogLog filter: config registers and wiring.
// Depends on ellf_pkg, ellf_front, ellf_queue and ellf_back.
//
// Channel  Dir  Fields (low bit first)
// s_*      in   item_key, arrival_index, random_one, random_two, random_three
// m_*      out  reported_key, over_threshold, counter_sum (40 bits, no pad)
// cfg_*    in   write enable, register index, 32-bit data
//
// The front accepts an item, then hashes its key (two shared multiplies, then per stage a
// seed mix, multiplies and a final xor-shift), takes reciprocal remainders for bucket index
// and window, and holds the request until the queue takes it, taking no new item meanwhile.
// The back does the table read-modify-write in read and update states; it overlaps the front.
// After reset the back clears each table entry by entry; s_tready stays low until then.
// A finished result waits in the output register while the next item is hashed.
`default_nettype none
module expiring_loglog_three_stage_filter_unit #(
	parameter int              BUCKETS       = 4096,
	parameter longint unsigned WINDOW_LENGTH = 1000000
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [159:0] s_tdata,  // item_key, arrival_index, random_one/two/three
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata,  // reported_key, over_threshold, counter_sum
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW    = $bits(ellf_pkg::item_info_t) + 3 * IDX_W;

	logic [2:0][31:0]      seed_q;
	logic [6:0]            thr_q;
	logic                  clear_done;
	logic                  fpush_valid, fpush_ready, qpop_valid, qpop_ready;
	ellf_pkg::item_info_t  f_info, b_info;
	logic [2:0][IDX_W-1:0] f_idx, b_idx;
	logic [QW-1:0]         q_out;
	logic [31:0]           o_key;
	logic                  o_over;
	logic [6:0]            o_sum;

	// hold config; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q[0] <= 32'd1;
			seed_q[1] <= 32'd2;
			seed_q[2] <= 32'd2;
			thr_q     <= 7'd8;
		end else if (cfg_we) begin
			case (ellf_pkg::cfg_reg_t'(cfg_index))
				ellf_pkg::REG_SEED_ONE:   seed_q[0] <= cfg_data;
				ellf_pkg::REG_SEED_TWO:   seed_q[1] <= cfg_data;
				ellf_pkg::REG_SEED_THREE: seed_q[2] <= cfg_data;
				ellf_pkg::REG_THRESHOLD:  thr_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	ellf_front #(.BUCKETS(BUCKETS), .WINDOW_LENGTH(WINDOW_LENGTH), .IDX_W(IDX_W)) u_front (
		.clk(clk), .arst_n(arst_n), .enable(clear_done),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.seeds(seed_q),
		.push_valid(fpush_valid), .push_ready(fpush_ready),
		.push_info(f_info), .push_idx(f_idx)
	);

	ellf_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fpush_valid), .push_ready(fpush_ready), .push_data({f_idx, f_info}),
		.pop_valid(qpop_valid), .pop_ready(qpop_ready), .pop_data(q_out)
	);

	assign b_info = q_out[$bits(ellf_pkg::item_info_t)-1:0];
	assign b_idx  = q_out[QW-1:$bits(ellf_pkg::item_info_t)];

	ellf_back #(.BUCKETS(BUCKETS), .IDX_W(IDX_W)) u_back (
		.clk(clk), .arst_n(arst_n), .clear_done(clear_done),
		.pop_valid(qpop_valid), .pop_ready(qpop_ready),
		.pop_info(b_info), .pop_idx(b_idx), .threshold(thr_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_key(o_key), .out_over(o_over), .out_sum(o_sum)
	);

	assign m_tdata = {o_sum, o_over, o_key};
endmodule
`default_nettype wire
